FILE: hw/rtl/drt_pkg.sv
// shared constants, types and decode helpers for the difficulty retarget block
`timescale 1ns / 1ps
package drt_pkg;

   localparam int TARGET_BITS = 256;
   localparam int MANT_W      = 23;
   localparam int SPAN_W      = 34;
   localparam int PROD_W      = MANT_W + SPAN_W;
   localparam int NBYTES      = TARGET_BITS / 8;
   localparam int SH_W        = $clog2(NBYTES);
   localparam int NB_W        = $clog2(NBYTES + 2);
   localparam int DIV_STEP    = 8;
   localparam int DIV_STAGES  = TARGET_BITS / DIV_STEP;

   localparam logic [1:0] REG_NO_RETARGET   = 2'd0;
   localparam logic [1:0] REG_TARGET_SPAN   = 2'd1;
   localparam logic [1:0] REG_LIMIT_COMPACT = 2'd2;

   localparam logic [31:0] TARGET_SPAN_RST   = 32'd1209600;
   localparam logic [31:0] LIMIT_COMPACT_RST = 32'h1d00ffff;

   typedef struct packed {
      logic              zero;
      logic [SH_W-1:0]   sh;
      logic [MANT_W-1:0] mant;
   } dec_type;

   // split a compact word into mantissa and byte shift, sign bit dropped
   function automatic dec_type decode(input logic [31:0] c);
      dec_type     d;
      logic [7:0]  size;
      logic [7:0]  sz3;
      logic [MANT_W-1:0] word;
      size = c[31:24];
      word = c[MANT_W-1:0];
      sz3  = size - 8'd3;
      d.zero = 1'b0;
      d.sh   = '0;
      case (size)
         8'd0:    d.mant = '0;
         8'd1:    d.mant = word >> 16;
         8'd2:    d.mant = word >> 8;
         8'd3:    d.mant = word;
         default: begin
            d.mant = word;
            d.sh   = sz3[SH_W-1:0];
            d.zero = (sz3 >= 8'(NBYTES));
         end
      endcase
      return d;
   endfunction

   function automatic logic [TARGET_BITS-1:0] expand(input dec_type d);
      logic [TARGET_BITS-1:0] t;
      t = {{(TARGET_BITS-MANT_W){1'b0}}, d.mant} << {d.sh, 3'b000};
      return d.zero ? '0 : t;
   endfunction

endpackage

FILE: hw/rtl/drt_if.sv
// handshake channels of the difficulty retarget block
`timescale 1ns / 1ps
interface drt_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] last_bits;
   logic [31:0] last_time;
   logic [31:0] first_time;
   modport source(output valid, last_bits, last_time, first_time, input ready);
   modport sink(input valid, last_bits, last_time, first_time, output ready);
endinterface

interface drt_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] new_bits;
   modport source(output valid, new_bits, input ready);
   modport sink(input valid, new_bits, output ready);
endinterface

interface drt_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [31:0] data;
   modport source(output valid, index, data, input ready);
   modport sink(input valid, index, data, output ready);
endinterface

FILE: hw/rtl/drt_divider.sv
// pipelined restoring divider, eight quotient bits per stage
`timescale 1ns / 1ps
module drt_divider (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             en,
   input  logic                             in_valid,
   input  logic [drt_pkg::TARGET_BITS-1:0]  in_num,
   input  logic [31:0]                      in_tag,
   input  logic [31:0]                      divisor,
   output logic                             out_valid,
   output logic [drt_pkg::TARGET_BITS-1:0]  out_quo,
   output logic [31:0]                      out_tag
);
   localparam int N = drt_pkg::DIV_STAGES;

   logic                            vld_ff  [N];
   logic [31:0]                     rem_ff  [N];
   logic [drt_pkg::TARGET_BITS-1:0] work_ff [N];
   logic [31:0]                     tag_ff  [N];

   logic                            src_vld  [N];
   logic [31:0]                     src_rem  [N];
   logic [drt_pkg::TARGET_BITS-1:0] src_work [N];
   logic [31:0]                     src_tag  [N];

   assign src_vld[0]  = in_valid;
   assign src_rem[0]  = '0;
   assign src_work[0] = in_num;
   assign src_tag[0]  = in_tag;

   for (genvar k = 0; k < N; k++) begin : g_stage
      logic [31:0]                     rem_in;
      logic [drt_pkg::TARGET_BITS-1:0] work_in;

      if (k > 0) begin : g_link
         assign src_vld[k]  = vld_ff[k-1];
         assign src_rem[k]  = rem_ff[k-1];
         assign src_work[k] = work_ff[k-1];
         assign src_tag[k]  = tag_ff[k-1];
      end

      // dividend bits leave at the top, quotient bits enter at the bottom
      always_comb begin
         logic [32:0] cur;
         logic        q;
         rem_in  = src_rem[k];
         work_in = src_work[k];
         for (int i = 0; i < drt_pkg::DIV_STEP; i++) begin
            cur = {rem_in, work_in[drt_pkg::TARGET_BITS-1]};
            q   = (cur >= {1'b0, divisor});
            rem_in  = q ? 32'(cur - {1'b0, divisor}) : cur[31:0];
            work_in = {work_in[drt_pkg::TARGET_BITS-2:0], q};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (en) begin
            vld_ff[k] <= src_vld[k];
         end
         if (en) begin
            rem_ff[k]  <= rem_in;
            work_ff[k] <= work_in;
            tag_ff[k]  <= src_tag[k];
         end
      end
   end

   assign out_valid = vld_ff[N-1];
   assign out_quo   = work_ff[N-1];
   assign out_tag   = tag_ff[N-1];
endmodule

FILE: hw/rtl/difficulty_retarget.sv
// top level of the compact-target difficulty retarget pipeline
`timescale 1ns / 1ps
// Takes one beat per cycle when the result side does not stall and returns
// one beat per input, in order, through span clamp and decode, a 23x34
// mantissa multiply, the byte shift into a 256-bit target, 32 divider
// stages of eight quotient bits each, the cap at the limit, and a two-stage
// compact encode. A stall on the result side holds the whole pipe.
// Configuration writes are taken at once; write them only while no beat is
// in flight.
module difficulty_retarget (
   input logic        clock,
   input logic        reset,
   drt_req_if.sink    req,
   drt_rsp_if.source  rsp,
   drt_csr_if.sink    csr
);
   localparam int TB = drt_pkg::TARGET_BITS;

   logic        no_retarget_ff;
   logic [31:0] target_span_ff;
   logic [31:0] limit_compact_ff;
   logic [TB-1:0] lim_ff;

   logic en;
   logic rsp_valid_ff;
   logic [31:0] rsp_bits_ff;

   assign en        = !rsp_valid_ff || rsp.ready;
   assign req.ready = en;
   assign csr.ready = 1'b1;
   assign rsp.valid    = rsp_valid_ff;
   assign rsp.new_bits = rsp_bits_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         no_retarget_ff   <= 1'b0;
         target_span_ff   <= drt_pkg::TARGET_SPAN_RST;
         limit_compact_ff <= drt_pkg::LIMIT_COMPACT_RST;
      end else if (csr.valid) begin
         unique case (csr.index)
            drt_pkg::REG_NO_RETARGET:   no_retarget_ff   <= csr.data[0];
            drt_pkg::REG_TARGET_SPAN:   target_span_ff   <= csr.data;
            drt_pkg::REG_LIMIT_COMPACT: limit_compact_ff <= csr.data;
            default: ;
         endcase
      end
      lim_ff <= drt_pkg::expand(drt_pkg::decode(limit_compact_ff));
   end

   // stage a: clamp the span and decode the old target
   logic [32:0] diff;
   logic [drt_pkg::SPAN_W-1:0] lo_b, hi_b, span_in;
   drt_pkg::dec_type dec_in;
   assign diff = {1'b0, req.last_time} - {1'b0, req.first_time};
   assign lo_b = {4'b0000, target_span_ff[31:2]};
   assign hi_b = {target_span_ff, 2'b00};
   assign dec_in = drt_pkg::decode(req.last_bits);

   always_comb begin
      if (diff[32] || ({1'b0, diff} < lo_b)) begin
         span_in = lo_b;
      end else if ({1'b0, diff} > hi_b) begin
         span_in = hi_b;
      end else begin
         span_in = {1'b0, diff};
      end
   end

   logic a_vld_ff;
   logic [drt_pkg::SPAN_W-1:0] a_span_ff;
   drt_pkg::dec_type a_dec_ff;
   logic [31:0] a_tag_ff;

   // stage b: mantissa times span
   logic b_vld_ff;
   logic [drt_pkg::PROD_W-1:0] b_prod_ff;
   logic [drt_pkg::SH_W-1:0] b_sh_ff;
   logic b_zero_ff;
   logic [31:0] b_tag_ff;

   // stage c: shift into the full-width target, wrapping
   logic c_vld_ff;
   logic [TB-1:0] c_num_ff;
   logic [31:0] c_tag_ff;
   logic [TB-1:0] c_num_in;
   assign c_num_in = b_zero_ff ? '0 :
      ({{(TB-drt_pkg::PROD_W){1'b0}}, b_prod_ff} << {b_sh_ff, 3'b000});

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
         b_vld_ff <= 1'b0;
         c_vld_ff <= 1'b0;
      end else if (en) begin
         a_vld_ff <= req.valid;
         b_vld_ff <= a_vld_ff;
         c_vld_ff <= b_vld_ff;
      end
      if (en) begin
         a_span_ff <= span_in;
         a_dec_ff  <= dec_in;
         a_tag_ff  <= req.last_bits;
         b_prod_ff <= drt_pkg::PROD_W'(a_dec_ff.mant) * drt_pkg::PROD_W'(a_span_ff);
         b_sh_ff   <= a_dec_ff.sh;
         b_zero_ff <= a_dec_ff.zero;
         b_tag_ff  <= a_tag_ff;
         c_num_ff  <= c_num_in;
         c_tag_ff  <= b_tag_ff;
      end
   end

   logic d_vld;
   logic [TB-1:0] d_quo;
   logic [31:0] d_tag;

   drt_divider u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (c_vld_ff),
      .in_num    (c_num_ff),
      .in_tag    (c_tag_ff),
      .divisor   (target_span_ff),
      .out_valid (d_vld),
      .out_quo   (d_quo),
      .out_tag   (d_tag)
   );

   // cap at the limit
   logic e_vld_ff;
   logic [TB-1:0] e_val_ff;
   logic [31:0] e_tag_ff;

   // byte length of the capped target
   logic f_vld_ff;
   logic [TB-1:0] f_val_ff;
   logic [drt_pkg::NB_W-1:0] f_nb_ff;
   logic [31:0] f_tag_ff;
   logic [drt_pkg::NB_W-1:0] nb_in;

   always_comb begin
      nb_in = '0;
      for (int i = 0; i < drt_pkg::NBYTES; i++) begin
         if (e_val_ff[8*i +: 8] != 8'd0) begin
            nb_in = drt_pkg::NB_W'(i + 1);
         end
      end
   end

   // final encode
   logic [23:0] win;
   logic [23:0] cmp;
   logic [7:0]  nb8;
   logic [31:0] enc;
   logic [drt_pkg::NB_W-1:0] pos;
   assign pos = f_nb_ff - drt_pkg::NB_W'(3);

   always_comb begin
      if (f_nb_ff <= drt_pkg::NB_W'(3)) begin
         win = f_val_ff[23:0] << {(2'd3 - f_nb_ff[1:0]), 3'b000};
      end else begin
         win = 24'(f_val_ff >> {pos, 3'b000});
      end
      nb8 = 8'(f_nb_ff);
      cmp = win;
      if (win[23]) begin
         cmp = win >> 8;
         nb8 = nb8 + 8'd1;
      end
      enc = {nb8, cmp};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e_vld_ff     <= 1'b0;
         f_vld_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         e_vld_ff     <= d_vld;
         f_vld_ff     <= e_vld_ff;
         rsp_valid_ff <= f_vld_ff;
      end
      if (en) begin
         e_val_ff    <= (d_quo > lim_ff) ? lim_ff : d_quo;
         e_tag_ff    <= d_tag;
         f_val_ff    <= e_val_ff;
         f_nb_ff     <= nb_in;
         f_tag_ff    <= e_tag_ff;
         rsp_bits_ff <= no_retarget_ff ? f_tag_ff : enc;
      end
   end
endmodule
